// ===== sv/mseu_pkg.sv =====
// Package for the MIPS subset execute unit: widths, opcodes, item and port types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mseu_pkg;

   localparam int DATA_W         = 32;
   localparam int REG_COUNT      = 32;
   localparam int REG_AW         = $clog2(REG_COUNT);
   localparam int MEM_WORDS      = 4096;
   localparam int MEM_AW         = $clog2(MEM_WORDS);
   localparam int PROG_WORDS     = 1024;
   localparam int PC_W           = $clog2(PROG_WORDS);
   localparam int IMM_W          = 16;
   localparam int BYTES_PER_WORD = 4;
   localparam int OP_W           = 4;

   localparam logic [REG_AW-1:0] ZERO_REG = REG_AW'(0);
   localparam logic [REG_AW-1:0] SP_REG   = REG_AW'(29);
   localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(31);
   localparam logic [DATA_W-1:0] SP_RESET_VALUE = DATA_W'(BYTES_PER_WORD * MEM_WORDS);

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 4'd0,
      OP_ADDI = 4'd1,
      OP_BGT  = 4'd2,
      OP_SLT  = 4'd3,
      OP_J    = 4'd4,
      OP_JAL  = 4'd5,
      OP_JR   = 4'd6,
      OP_BNE  = 4'd7,
      OP_LW   = 4'd8,
      OP_SW   = 4'd9,
      OP_MOVE = 4'd10,
      OP_RET  = 4'd11,
      OP_NOP  = 4'd12
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [REG_AW-1:0]  dest_reg;
      logic [REG_AW-1:0]  src_a;
      logic [REG_AW-1:0]  src_b;
      logic [IMM_W-1:0]   immediate;
      logic [PC_W-1:0]    target;
   } instr_type;

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              halted;
      logic              bad_opcode;
      logic              reg_written;
      logic              load;
      logic [REG_AW-1:0] wreg;
      logic [DATA_W-1:0] wval;
   } stage_type;

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              halted;
      logic              bad_opcode;
      logic              reg_written;
      logic [DATA_W-1:0] written_value;
   } result_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr_a;
      logic [REG_AW-1:0] addr_b;
   } rf_read_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [DATA_W-1:0] data;
   } rf_write_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [MEM_AW-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_port_type;

   function automatic logic [DATA_W-1:0] reg_reset_value(input logic [REG_AW-1:0] addr);
      return (addr == SP_REG) ? SP_RESET_VALUE : '0;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mseu_regfile.sv =====
// Register file: 32 x 32 RAM, two registered read ports, one write port.
// Valid bits give the reset contents of entries not yet written. Uses mseu_pkg.
`default_nettype none

module mseu_regfile
   import mseu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rf_read_type       rd_req,
   input  wire rf_write_type      wr_req,
   output logic [DATA_W-1:0]      rd_data_a,
   output logic [DATA_W-1:0]      rd_data_b
);

   logic [DATA_W-1:0]    reg_array_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [REG_COUNT-1:0] valid_in;
   logic [DATA_W-1:0]    data_a_ff;
   logic [DATA_W-1:0]    data_b_ff;
   logic                 valid_a_ff;
   logic                 valid_b_ff;
   logic [REG_AW-1:0]    addr_a_ff;
   logic [REG_AW-1:0]    addr_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_req.en) begin
         valid_in[wr_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         reg_array_ff[wr_req.addr] <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         data_a_ff  <= reg_array_ff[rd_req.addr_a];
         data_b_ff  <= reg_array_ff[rd_req.addr_b];
         valid_a_ff <= valid_ff[rd_req.addr_a];
         valid_b_ff <= valid_ff[rd_req.addr_b];
         addr_a_ff  <= rd_req.addr_a;
         addr_b_ff  <= rd_req.addr_b;
      end
   end

   assign rd_data_a = valid_a_ff ? data_a_ff : reg_reset_value(addr_a_ff);
   assign rd_data_b = valid_b_ff ? data_b_ff : reg_reset_value(addr_b_ff);

endmodule

`default_nettype wire

// ===== sv/mseu_stack_mem.sv =====
// Stack memory: MEM_WORDS x 32 single-port RAM with a registered read.
// Uses mseu_pkg.
`default_nettype none

module mseu_stack_mem
   import mseu_pkg::*;
(
   input  wire logic         clock,
   input  wire mem_port_type port,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] stack_ff [MEM_WORDS];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (port.en) begin
         if (port.we) begin
            stack_ff[port.addr] <= port.wdata;
         end else begin
            rdata_ff <= stack_ff[port.addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/mseu_exec.sv =====
// Execute pipeline: operand stage with forwarding, program counter, halt flag,
// result register, register file retire. Uses mseu_pkg.
`default_nettype none

module mseu_exec
   import mseu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire instr_type         req_instr,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output result_type             rsp_result,
   output rf_read_type            rf_rd,
   output rf_write_type           rf_wr,
   input  wire logic [DATA_W-1:0] rf_data_a,
   input  wire logic [DATA_W-1:0] rf_data_b,
   output mem_port_type           mem_port,
   input  wire logic [DATA_W-1:0] mem_rdata
);

   logic         s1_valid_ff, s1_valid_in;
   instr_type    s1_instr_ff;
   logic         s2_valid_ff, s2_valid_in;
   stage_type    s2_ff, s2_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic         halt_ff, halt_in;
   rf_write_type last_wr_ff, last_wr_in;

   logic              s2_free;
   logic              s1_free;
   logic              s1_adv;
   logic              accept;
   logic [DATA_W-1:0] s2_value;
   logic [DATA_W-1:0] op_a;
   logic [DATA_W-1:0] op_b;
   logic [DATA_W-1:0] simm;
   logic [DATA_W-1:0] addr_sum;
   logic [PC_W-1:0]   seq_pc;

   assign s2_free   = !s2_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign accept    = req_valid && s1_free;
   assign req_ready = s1_free;

   assign rf_rd.en     = accept;
   assign rf_rd.addr_a = req_instr.src_a;
   assign rf_rd.addr_b = req_instr.src_b;

   assign s2_value = s2_ff.load ? mem_rdata : s2_ff.wval;

   always_comb begin
      op_a = rf_data_a;
      op_b = rf_data_b;
      if (last_wr_ff.en && last_wr_ff.addr == s1_instr_ff.src_a) begin
         op_a = last_wr_ff.data;
      end
      if (last_wr_ff.en && last_wr_ff.addr == s1_instr_ff.src_b) begin
         op_b = last_wr_ff.data;
      end
      if (s2_valid_ff && s2_ff.reg_written && s2_ff.wreg == s1_instr_ff.src_a) begin
         op_a = s2_value;
      end
      if (s2_valid_ff && s2_ff.reg_written && s2_ff.wreg == s1_instr_ff.src_b) begin
         op_b = s2_value;
      end
   end

   assign simm     = {{(DATA_W-IMM_W){s1_instr_ff.immediate[IMM_W-1]}}, s1_instr_ff.immediate};
   assign addr_sum = op_a + simm;
   assign seq_pc   = pc_ff + PC_W'(1);

   always_comb begin
      s2_in.next_pc     = seq_pc;
      s2_in.halted      = 1'b0;
      s2_in.bad_opcode  = 1'b0;
      s2_in.reg_written = 1'b0;
      s2_in.load        = 1'b0;
      s2_in.wreg        = s1_instr_ff.dest_reg;
      s2_in.wval        = '0;
      halt_in           = halt_ff;
      mem_port.en       = 1'b0;
      mem_port.we       = 1'b0;
      mem_port.addr     = addr_sum[MEM_AW+1:2];
      mem_port.wdata    = op_b;
      if (halt_ff) begin
         s2_in.next_pc = pc_ff;
      end else begin
         unique case (s1_instr_ff.opcode)
            OP_ADD: begin
               s2_in.reg_written = 1'b1;
               s2_in.wval        = op_a + op_b;
            end
            OP_ADDI: begin
               s2_in.reg_written = 1'b1;
               s2_in.wval        = addr_sum;
            end
            OP_BGT: begin
               if ($signed(op_a) > $signed(op_b)) begin
                  s2_in.next_pc = s1_instr_ff.target;
               end
            end
            OP_SLT: begin
               s2_in.reg_written = 1'b1;
               s2_in.wval        = DATA_W'($signed(op_a) < $signed(op_b));
            end
            OP_J: begin
               s2_in.next_pc = s1_instr_ff.target;
            end
            OP_JAL: begin
               s2_in.reg_written = 1'b1;
               s2_in.wreg        = LINK_REG;
               s2_in.wval        = DATA_W'(seq_pc);
               s2_in.next_pc     = s1_instr_ff.target;
            end
            OP_JR: begin
               s2_in.next_pc = op_a[PC_W-1:0];
            end
            OP_BNE: begin
               if (op_a != op_b) begin
                  s2_in.next_pc = s1_instr_ff.target;
               end
            end
            OP_LW: begin
               s2_in.reg_written = 1'b1;
               s2_in.load        = 1'b1;
               mem_port.en       = s1_adv;
            end
            OP_SW: begin
               mem_port.en = s1_adv;
               mem_port.we = 1'b1;
            end
            OP_MOVE: begin
               s2_in.reg_written = 1'b1;
               s2_in.wval        = op_a;
            end
            OP_RET: begin
               halt_in       = 1'b1;
               s2_in.next_pc = pc_ff;
            end
            OP_NOP: begin
            end
            default: begin
               halt_in          = 1'b1;
               s2_in.bad_opcode = 1'b1;
               s2_in.next_pc    = pc_ff;
            end
         endcase
         if (s2_in.reg_written && s2_in.wreg == ZERO_REG) begin
            s2_in.reg_written = 1'b0;
            s2_in.load        = 1'b0;
            s2_in.wval        = '0;
         end
      end
      s2_in.halted = halt_in;
      pc_in        = s2_in.next_pc;
   end

   always_comb begin
      s1_valid_in = s1_free ? req_valid : s1_valid_ff;
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
      rf_wr.en    = s2_valid_ff && rsp_ready && s2_ff.reg_written;
      rf_wr.addr  = s2_ff.wreg;
      rf_wr.data  = s2_value;
      last_wr_in  = rf_wr.en ? rf_wr : last_wr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         pc_ff         <= '0;
         halt_ff       <= 1'b0;
         last_wr_ff.en <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         last_wr_ff  <= last_wr_in;
         if (s1_adv) begin
            pc_ff   <= pc_in;
            halt_ff <= halt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instr;
      end
      if (s1_adv) begin
         s2_ff <= s2_in;
      end
   end

   assign rsp_valid                = s2_valid_ff;
   assign rsp_result.next_pc       = s2_ff.next_pc;
   assign rsp_result.halted        = s2_ff.halted;
   assign rsp_result.bad_opcode    = s2_ff.bad_opcode;
   assign rsp_result.reg_written   = s2_ff.reg_written;
   assign rsp_result.written_value = s2_ff.reg_written ? s2_value : '0;

endmodule

`default_nettype wire

// ===== sv/mips_subset_execute_unit.sv =====
// MIPS subset execute unit: one pre-decoded instruction per item, one result per item.
// An accepted item is registered in stage 1, then in the stage 2 result register, which drives the result.
// Throughput: one item per cycle; forwarding removes dependency stalls, and the input
// stalls only while both pipeline stages are full and rsp_tready is low.
// Reset: synchronous; clears pipeline, program counter, halt flag and register valid bits.
// Depends on mseu_pkg, mseu_regfile, mseu_stack_mem and mseu_exec.
`default_nettype none

module mips_subset_execute_unit
   import mseu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // dest_reg[4:0], src_a[9:5], src_b[14:10], immediate[30:15], target[40:31]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[3:0]
   input  wire logic [OP_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // next_pc[9:0], written_value[41:10]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // halted[0], bad_opcode[1], reg_written[2]
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   instr_type         req_instr;
   result_type        rsp_result;
   rf_read_type       rf_rd;
   rf_write_type      rf_wr;
   logic [DATA_W-1:0] rf_data_a;
   logic [DATA_W-1:0] rf_data_b;
   mem_port_type      mem_port;
   logic [DATA_W-1:0] mem_rdata;

   assign req_instr.opcode    = opcode_type'(req_tuser);
   assign req_instr.dest_reg  = req_tdata[4:0];
   assign req_instr.src_a     = req_tdata[9:5];
   assign req_instr.src_b     = req_tdata[14:10];
   assign req_instr.immediate = req_tdata[30:15];
   assign req_instr.target    = req_tdata[40:31];

   mseu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_req    (rf_rd),
      .wr_req    (rf_wr),
      .rd_data_a (rf_data_a),
      .rd_data_b (rf_data_b)
   );

   mseu_stack_mem u_stack_mem (
      .clock (clock),
      .port  (mem_port),
      .rdata (mem_rdata)
   );

   mseu_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_instr  (req_instr),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result),
      .rf_rd      (rf_rd),
      .rf_wr      (rf_wr),
      .rf_data_a  (rf_data_a),
      .rf_data_b  (rf_data_b),
      .mem_port   (mem_port),
      .mem_rdata  (mem_rdata)
   );

   assign rsp_tdata = {(RSP_DATA_W-DATA_W-PC_W)'(0), rsp_result.written_value,
                       rsp_result.next_pc};
   assign rsp_tuser = {rsp_result.reg_written, rsp_result.bad_opcode, rsp_result.halted};

endmodule

`default_nettype wire

// ===== sv/mseu_checker.sv =====
// Port-level checker for mips_subset_execute_unit, bound to the top level.
// Uses mseu_pkg for field positions.
`default_nettype none

module mseu_checker
   import mseu_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   logic            seen_halt_ff;
   logic [PC_W-1:0] halt_pc_ff;
   logic            rsp_take;

   assign rsp_take = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_take && rsp_tuser[0] && !seen_halt_ff) begin
         seen_halt_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take && rsp_tuser[0] && !seen_halt_ff) begin
         halt_pc_ff <= rsp_tdata[PC_W-1:0];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_halt_ff |-> rsp_tuser[0] && !rsp_tuser[1] && !rsp_tuser[2]
                                    && rsp_tdata[PC_W-1:0] == halt_pc_ff)
      else $error("item after halt changed state");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && !rsp_tuser[2])
      else $error("bad opcode without halt");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> rsp_tdata[PC_W+DATA_W-1:PC_W] == '0)
      else $error("written value without register write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

endmodule

bind mips_subset_execute_unit mseu_checker u_mseu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
